// File: src/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_READ   = 2'd1,
    FN_SHRINK = 2'd2,
    FN_TRIM   = 2'd3
  } func_t;

  localparam logic [1:0] TRIT_UNKNOWN = 2'd0;
  localparam logic [1:0] TRIT_FALSE   = 2'd1;
  localparam logic [1:0] TRIT_TRUE    = 2'd2;
  localparam logic [1:0] TRIT_BAD     = 2'd3;

  localparam int TRITS_PER_WORD = 16;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SWP_RD,
    ST_SWP_WR,
    ST_TRES,
    ST_SCN_RD,
    ST_SCN_CHK,
    ST_LEN_RD,
    ST_LEN
  } state_t;

  function automatic logic [1:0] trit_at(input logic [31:0] word, input logic [3:0] k);
    return word[{~k, 1'b0} +: 2];
  endfunction

  function automatic logic [31:0] trit_put(input logic [31:0] word, input logic [3:0] k,
                                           input logic [1:0] v);
    logic [31:0] w;
    w = word;
    w[{~k, 1'b0} +: 2] = v;
    return w;
  endfunction

  function automatic logic [31:0] trit_keep(input logic [31:0] word, input logic [3:0] k);
    logic [31:0] w;
    w = word;
    for (int i = 0; i < TRITS_PER_WORD; i++) begin
      if (4'(i) > k) w[{~4'(i), 1'b0} +: 2] = TRIT_UNKNOWN;
    end
    return w;
  endfunction

  function automatic logic [4:0] trit_count(input logic [31:0] word, input logic [1:0] code);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < TRITS_PER_WORD; i++) begin
      if (word[{~4'(i), 1'b0} +: 2] == code) n = n + 5'd1;
    end
    return n;
  endfunction

  function automatic logic [4:0] trit_last(input logic [31:0] word);
    logic [4:0] j;
    j = 5'd0;
    for (int i = 0; i < TRITS_PER_WORD; i++) begin
      if (word[{~4'(i), 1'b0} +: 2] != TRIT_UNKNOWN) j = 5'(i + 1);
    end
    return j;
  endfunction

endpackage

// File: src/packed_trit_store.sv
`timescale 1ns / 1ps
// Packed trit store: trits live sixteen to a word in one single-port-per-side
// synchronous RAM of MAX_WORDS words. Write, read and shrink all run word
// read, read-modify-write, read of the last non-zero word for the length, and
// result. A trim within the allocation adds a step, plus a read and a clearing
// write per word above the trimmed word up to the last non-zero word, and any
// operation that empties the last non-zero word adds a read and a check per
// word searched downward for the new one. After reset and every initial_trits
// write, a clearing pass zeroes all MAX_WORDS words while no request is taken.
module packed_trit_store import pts_pkg::*; #(
  parameter int MAX_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [9:0]  index,
  input  logic [1:0]  value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  read_value,
  output logic [10:0] size_trits,
  output logic [10:0] num_true,
  output logic [10:0] num_false,
  output logic [10:0] num_unknown,
  output logic [10:0] length,
  output logic        error
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);

  function automatic logic [CW-1:0] words_for(input logic [10:0] t);
    logic [7:0] n;
    n = (t == 11'd0) ? 8'd1 : 8'((12'(t) + 12'd15) >> 4);
    if (32'(n) > MAX_WORDS) return CW'(MAX_WORDS);
    return CW'(n);
  endfunction

  logic [31:0] mem [MAX_WORDS];
  logic [31:0] rdata;
  logic        rd_en, wr_en;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] wdata;

  state_t state, state_next;
  logic [10:0] init_trits, init_trits_next;
  logic [CW-1:0] alloc, alloc_next;
  logic [10:0] tot_t, tot_t_next, tot_f, tot_f_next;
  logic [AW-1:0] lw, lw_next, cur, cur_next;
  logic lw_ok, lw_ok_next;
  func_t op, op_next;
  logic [9:0] ridx, ridx_next;
  logic [1:0] rval, rval_next;
  logic [31:0] wnew, wnew_next;
  logic err, err_next, trim_nz, trim_nz_next;
  logic out_load;

  logic [5:0] rw;
  logic [3:0] rk;
  logic [AW-1:0] wa;
  logic in_max, beyond, trim_ok, do_wr;
  logic [31:0] wn;

  assign rw = ridx[9:4];
  assign rk = ridx[3:0];
  assign wa = AW'(rw);
  assign in_max = 32'(rw) < MAX_WORDS;
  assign beyond = 32'(rw) >= 32'(alloc);
  assign trim_ok = (32'(ridx) + 32'd1) <= (32'(alloc) << 4);

  always_comb begin
    wn = rdata;
    do_wr = 1'b0;
    case (op)
      FN_WRITE: begin
        wn = trit_put(rdata, rk, rval);
        do_wr = in_max && !(beyond && rval == TRIT_UNKNOWN);
      end
      FN_TRIM: begin
        wn = trit_keep(rdata, rk);
        do_wr = trim_ok;
      end
      default: begin
        wn = rdata;
        do_wr = 1'b0;
      end
    endcase
  end

  assign out_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state == ST_IDLE) && !cfg_valid;
    cfg_ready = (state == ST_IDLE) || (state == ST_CLEAR);
    rd_en = 1'b0;
    raddr = cur;
    wr_en = 1'b0;
    waddr = cur;
    wdata = 32'd0;
    case (state)
      ST_CLEAR: wr_en = 1'b1;
      ST_IDLE: begin
        rd_en = in_valid && in_ready;
        raddr = AW'(index[9:4]);
      end
      ST_MOD: begin
        wr_en = do_wr;
        waddr = wa;
        wdata = wn;
      end
      ST_SWP_RD, ST_SCN_RD: rd_en = 1'b1;
      ST_SWP_WR: wr_en = 1'b1;
      ST_LEN_RD: begin
        rd_en = 1'b1;
        raddr = lw;
      end
      default: rd_en = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    init_trits_next = init_trits;
    alloc_next = alloc;
    tot_t_next = tot_t;
    tot_f_next = tot_f;
    lw_next = lw;
    lw_ok_next = lw_ok;
    cur_next = cur;
    op_next = op;
    ridx_next = ridx;
    rval_next = rval;
    wnew_next = wnew;
    err_next = err;
    trim_nz_next = trim_nz;
    case (state)
      ST_CLEAR: begin
        cur_next = cur + AW'(1);
        if (32'(cur) == MAX_WORDS - 1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          op_next = func_t'(func);
          ridx_next = index;
          rval_next = (value == TRIT_BAD) ? TRIT_UNKNOWN : value;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        err_next = (op == FN_WRITE) && !in_max;
        wnew_next = do_wr ? wn : rdata;
        state_next = ST_LEN_RD;
        if (do_wr) begin
          tot_t_next = tot_t - 11'(trit_count(rdata, TRIT_TRUE))
                       + 11'(trit_count(wn, TRIT_TRUE));
          tot_f_next = tot_f - 11'(trit_count(rdata, TRIT_FALSE))
                       + 11'(trit_count(wn, TRIT_FALSE));
        end
        case (op)
          FN_WRITE: begin
            if (do_wr) begin
              if (beyond) alloc_next = CW'(32'(rw) + 32'd1);
              if (wn != 32'd0) begin
                if (!lw_ok || wa > lw) begin
                  lw_next = wa;
                  lw_ok_next = 1'b1;
                end
              end else if (lw_ok && wa == lw) begin
                if (wa == AW'(0)) lw_ok_next = 1'b0;
                else begin
                  cur_next = wa - AW'(1);
                  state_next = ST_SCN_RD;
                end
              end
            end
          end
          FN_SHRINK: alloc_next = lw_ok ? CW'(32'(lw) + 32'd1) : words_for(init_trits);
          FN_TRIM: begin
            if (do_wr) begin
              alloc_next = CW'(32'(rw) + 32'd1);
              trim_nz_next = wn != 32'd0;
              if (lw_ok && lw > wa) begin
                cur_next = wa + AW'(1);
                state_next = ST_SWP_RD;
              end else begin
                state_next = ST_TRES;
              end
            end
          end
          default: state_next = ST_LEN_RD;
        endcase
      end
      ST_SWP_RD: state_next = ST_SWP_WR;
      ST_SWP_WR: begin
        tot_t_next = tot_t - 11'(trit_count(rdata, TRIT_TRUE));
        tot_f_next = tot_f - 11'(trit_count(rdata, TRIT_FALSE));
        if (cur == lw) state_next = ST_TRES;
        else begin
          cur_next = cur + AW'(1);
          state_next = ST_SWP_RD;
        end
      end
      ST_TRES: begin
        state_next = ST_LEN_RD;
        if (trim_nz) begin
          lw_next = wa;
          lw_ok_next = 1'b1;
        end else if (lw_ok && lw >= wa) begin
          if (wa == AW'(0)) lw_ok_next = 1'b0;
          else begin
            cur_next = wa - AW'(1);
            state_next = ST_SCN_RD;
          end
        end
      end
      ST_SCN_RD: state_next = ST_SCN_CHK;
      ST_SCN_CHK: begin
        if (rdata != 32'd0) begin
          lw_next = cur;
          state_next = ST_LEN_RD;
        end else if (cur == AW'(0)) begin
          lw_ok_next = 1'b0;
          state_next = ST_LEN_RD;
        end else begin
          cur_next = cur - AW'(1);
          state_next = ST_SCN_RD;
        end
      end
      ST_LEN_RD: state_next = ST_LEN;
      ST_LEN: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (cfg_valid && cfg_ready) begin
      init_trits_next = cfg_data;
      alloc_next = words_for(cfg_data);
      tot_t_next = 11'd0;
      tot_f_next = 11'd0;
      lw_ok_next = 1'b0;
      cur_next = AW'(0);
      state_next = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      init_trits <= 11'd16;
      alloc <= words_for(11'd16);
      tot_t <= 11'd0;
      tot_f <= 11'd0;
      lw_ok <= 1'b0;
      cur <= AW'(0);
    end else begin
      state <= state_next;
      init_trits <= init_trits_next;
      alloc <= alloc_next;
      tot_t <= tot_t_next;
      tot_f <= tot_f_next;
      lw_ok <= lw_ok_next;
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    lw <= lw_next;
    op <= op_next;
    ridx <= ridx_next;
    rval <= rval_next;
    wnew <= wnew_next;
    err <= err_next;
    trim_nz <= trim_nz_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LEN && out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LEN && out_load) begin
      read_value <= (32'(rw) < 32'(alloc)) ? trit_at(wnew, rk) : TRIT_UNKNOWN;
      size_trits <= 11'(32'(alloc) << 4);
      num_true <= tot_t;
      num_false <= tot_f;
      num_unknown <= lw_ok ? 11'(((32'(lw) + 32'd1) << 4) - 32'(tot_t) - 32'(tot_f))
                           : 11'd0;
      length <= lw_ok ? 11'((32'(lw) << 4) + 32'(trit_last(rdata))) : 11'd0;
      error <= err;
    end
  end

endmodule

// File: src/pts_checker.sv
`timescale 1ns / 1ps
module pts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  read_value,
  input logic [10:0] size_trits,
  input logic [10:0] num_true,
  input logic [10:0] num_false,
  input logic [10:0] num_unknown,
  input logic [10:0] length,
  input logic        error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(length) && $stable(read_value))
    else $error("result dropped or changed while stalled");

  a_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> size_trits[3:0] == 4'd0)
    else $error("size not whole words");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> read_value == 2'd0)
    else $error("failed write reports a trit");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length == 11'd0) ==
      ((12'(num_unknown) + 12'(num_true) + 12'(num_false)) == 12'd0))
    else $error("length and counts disagree on empty");

endmodule

bind packed_trit_store pts_checker u_pts_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .read_value(read_value), .size_trits(size_trits), .num_true(num_true),
  .num_false(num_false), .num_unknown(num_unknown), .length(length),
  .error(error)
);

// File: sim/tb_packed_trit_store.sv
`timescale 1ns / 1ps
module tb_packed_trit_store import pts_pkg::*; ();

  typedef struct packed {
    logic [1:0]  read_value;
    logic [10:0] size_trits;
    logic [10:0] num_true;
    logic [10:0] num_false;
    logic [10:0] num_unknown;
    logic [10:0] length;
    logic        error;
  } trit_result_t;

  class trit_scoreboard;
    localparam int NWORDS = 64;
    logic [31:0]  words [NWORDS];
    int unsigned  alloc_words;
    int unsigned  n_true;
    int unsigned  n_false;
    logic [10:0]  start_trits;
    trit_result_t pending [$];
    int unsigned  fails;

    function int unsigned words_for(logic [10:0] t);
      int unsigned n;
      n = (t == 0) ? 1 : (int'(t) + 15) / 16;
      if (n > NWORDS) n = NWORDS;
      return n;
    endfunction

    function void restart(logic [10:0] t);
      start_trits = t;
      foreach (words[i]) words[i] = '0;
      alloc_words = words_for(t);
      n_true = 0;
      n_false = 0;
    endfunction

    function logic [1:0] get_trit(int unsigned w, int unsigned k);
      return words[w][30 - 2 * k +: 2];
    endfunction

    function void put_trit(int unsigned w, int unsigned k, logic [1:0] v);
      words[w][30 - 2 * k +: 2] = v;
    endfunction

    function void tally(logic [1:0] v, int d);
      if (v == TRIT_TRUE) n_true = n_true + d;
      else if (v == TRIT_FALSE) n_false = n_false + d;
    endfunction

    function int last_word();
      for (int w = int'(alloc_words) - 1; w >= 0; w--)
        if (words[w] != 0) return w;
      return -1;
    endfunction

    function void note_request(func_t fn, logic [9:0] idx, logic [1:0] val);
      int unsigned w, k, j, len, unk;
      int lw;
      trit_result_t r;
      w = idx / 16;
      k = idx % 16;
      len = 0;
      unk = 0;
      r = '0;
      if (val == TRIT_BAD) val = TRIT_UNKNOWN;
      case (fn)
        FN_WRITE: begin
          if (w >= NWORDS) begin
            r.error = 1'b1;
          end else if (w >= alloc_words) begin
            if (val != TRIT_UNKNOWN) begin
              alloc_words = w + 1;
              tally(val, 1);
              put_trit(w, k, val);
            end
          end else begin
            tally(get_trit(w, k), -1);
            tally(val, 1);
            put_trit(w, k, val);
          end
        end
        FN_SHRINK: begin
          lw = last_word();
          alloc_words = (lw >= 0) ? lw + 1 : words_for(start_trits);
        end
        FN_TRIM: begin
          if (idx + 1 <= alloc_words * 16) begin
            for (j = k + 1; j < 16; j++) begin
              tally(get_trit(w, j), -1);
              put_trit(w, j, TRIT_UNKNOWN);
            end
            for (int unsigned i = w + 1; i < alloc_words; i++) begin
              for (j = 0; j < 16; j++) tally(get_trit(i, j), -1);
              words[i] = '0;
            end
            alloc_words = w + 1;
          end
        end
        default: ;
      endcase
      if (w < alloc_words) r.read_value = get_trit(w, k);
      lw = last_word();
      if (lw >= 0) begin
        j = 16;
        while (j > 0 && get_trit(lw, j - 1) == TRIT_UNKNOWN) j--;
        len = lw * 16 + j;
        unk = (lw + 1) * 16 - n_true - n_false;
      end
      r.size_trits = 11'(alloc_words * 16);
      r.num_true = 11'(n_true);
      r.num_false = 11'(n_false);
      r.num_unknown = 11'(unk);
      r.length = 11'(len);
      pending.push_back(r);
    endfunction

    function void check_result(trit_result_t a);
      trit_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result");
        fails++;
        return;
      end
      e = pending.pop_front();
      if (a.read_value !== e.read_value) begin
        $error("read_value exp %0d got %0d", e.read_value, a.read_value); fails++;
      end
      if (a.size_trits !== e.size_trits) begin
        $error("size_trits exp %0d got %0d", e.size_trits, a.size_trits); fails++;
      end
      if (a.num_true !== e.num_true) begin
        $error("num_true exp %0d got %0d", e.num_true, a.num_true); fails++;
      end
      if (a.num_false !== e.num_false) begin
        $error("num_false exp %0d got %0d", e.num_false, a.num_false); fails++;
      end
      if (a.num_unknown !== e.num_unknown) begin
        $error("num_unknown exp %0d got %0d", e.num_unknown, a.num_unknown); fails++;
      end
      if (a.length !== e.length) begin
        $error("length exp %0d got %0d", e.length, a.length); fails++;
      end
      if (a.error !== e.error) begin
        $error("error exp %0d got %0d", e.error, a.error); fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [9:0]  index = '0;
  logic [1:0]  value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  read_value;
  logic [10:0] size_trits;
  logic [10:0] num_true;
  logic [10:0] num_false;
  logic [10:0] num_unknown;
  logic [10:0] length;
  logic        error;

  trit_scoreboard sb;
  bit          hold_off = 1'b0;

  always #2 clk = ~clk;

  packed_trit_store i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .index(index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .size_trits(size_trits), .num_true(num_true),
    .num_false(num_false), .num_unknown(num_unknown), .length(length),
    .error(error)
  );

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(func_t fn, logic [9:0] idx, logic [1:0] val, bit gaps);
    int unsigned g;
    g = gaps ? pick_gap() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    func <= fn;
    index <= idx;
    value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(fn, idx, val);
  endtask

  task automatic write_config(logic [10:0] t);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_data <= t;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.restart(t);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    func_t fn;
    logic [9:0] idx;
    logic [1:0] val;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) fn = FN_WRITE;
      else if (r < 80) fn = FN_READ;
      else if (r < 90) fn = FN_SHRINK;
      else fn = FN_TRIM;
      if ($urandom_range(0, 3) == 0) idx = 10'($urandom);
      else idx = 10'($urandom_range(0, sb.alloc_words * 16 + 31));
      r = $urandom_range(0, 9);
      val = (r < 4) ? TRIT_TRUE : (r < 8) ? TRIT_FALSE : (r < 9) ? TRIT_UNKNOWN : TRIT_BAD;
      send_request(fn, idx, val, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_result({read_value, size_trits, num_true, num_false,
                       num_unknown, length, error});
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 9) < 7);
  end

  initial begin
    sb = new();
    sb.restart(11'd16);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_request(FN_READ, 10'd0, TRIT_UNKNOWN, 1'b0);
    send_request(FN_WRITE, 10'd0, TRIT_TRUE, 1'b0);
    send_request(FN_WRITE, 10'd15, TRIT_FALSE, 1'b0);
    send_request(FN_WRITE, 10'd40, TRIT_UNKNOWN, 1'b0);
    send_request(FN_WRITE, 10'd40, TRIT_BAD, 1'b0);
    send_request(FN_WRITE, 10'd1023, TRIT_TRUE, 1'b0);
    send_request(FN_WRITE, 10'd1000, TRIT_FALSE, 1'b0);
    send_request(FN_WRITE, 10'd15, TRIT_UNKNOWN, 1'b0);
    send_request(FN_READ, 10'd1023, TRIT_UNKNOWN, 1'b0);
    send_request(FN_TRIM, 10'd1023, TRIT_UNKNOWN, 1'b0);
    send_request(FN_TRIM, 10'd200, TRIT_UNKNOWN, 1'b0);
    send_request(FN_SHRINK, 10'd0, TRIT_UNKNOWN, 1'b0);
    send_request(FN_TRIM, 10'd500, TRIT_UNKNOWN, 1'b0);
    send_request(FN_TRIM, 10'd0, TRIT_UNKNOWN, 1'b0);
    send_request(FN_WRITE, 10'd0, TRIT_UNKNOWN, 1'b0);
    send_request(FN_SHRINK, 10'd0, TRIT_UNKNOWN, 1'b0);
    send_request(FN_READ, 10'd682, TRIT_BAD, 1'b0);
    random_phase(200);
    write_config(11'd0);
    send_request(FN_SHRINK, 10'd0, TRIT_UNKNOWN, 1'b0);
    random_phase(150);
    write_config(11'd1024);
    hold_off = 1'b1;
    fork
      random_phase(150);
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    write_config(11'd2047);
    send_request(FN_SHRINK, 10'd0, TRIT_UNKNOWN, 1'b0);
    random_phase(150);
    write_config(11'd1);
    random_phase(125);
    write_config(11'($urandom_range(2, 1023)));
    random_phase(100);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.fails == 0) $display("packed_trit_store regression: pass");
    else $display("packed_trit_store regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("packed_trit_store regression: fail");
    $finish;
  end

endmodule
